[rtl/core/cleb_pkg.sv]
// Package: shared constants, types and codes for the cursor line-edit buffer.
`default_nettype none
package cleb_pkg;

   localparam int CAPACITY_DEF = 1024;
   localparam int QUEUE_DEPTH = 2;

   localparam int MODE_W = 3;
   localparam int CHAR_W = 8;
   localparam int POS_W = 10;
   localparam int STATUS_W = 2;
   localparam int LEN_W = 11;

   localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_LEFT = 3'd1;
   localparam logic [MODE_W-1:0] MODE_RIGHT = 3'd2;
   localparam logic [MODE_W-1:0] MODE_BACK = 3'd3;
   localparam logic [MODE_W-1:0] MODE_READ = 3'd4;

   localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BOUNDARY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_WRITE,
      OP_COPY,
      OP_READ
   } op_type;

   typedef enum logic {
      BK_IDLE,
      BK_FINISH
   } back_state_type;

   typedef struct packed {
      op_type              op;
      logic [CHAR_W-1:0]   wdata;
      logic [STATUS_W-1:0] status;
      logic [LEN_W-1:0]    text_length;
      logic [LEN_W-1:0]    cursor_pos;
   } cmd_info_type;

endpackage
`default_nettype wire

[rtl/core/cursor_line_edit_buffer.sv]
// Top level: cursor line-edit buffer (gap buffer in one single-port text memory).
//
// req_ channel takes one command per transaction: mode, char_in, read_pos.
// rsp_ channel returns exactly one transaction per command, in order, with
// char_out, status, text_length and cursor_pos after that command.
// The front end decodes the command, checks buffer bounds and updates the
// cursor counters at acceptance, then queues a memory command (2 deep).
// The back end runs the memory: inserts, deletes and refused commands are
// finished as they leave the queue; cursor moves and reads do a registered
// memory read, then the write or response, through the single memory port.
// Sustained rate: 1 command per cycle for inserts/deletes while rsp_ready is
// high; a move or read holds off the next command until its write or
// response is done.
// Reset empties the text (length and cursor zero); memory is not cleared.
// When rsp_ready is low the response register holds; the queue then fills
// and req_ready drops.
`default_nettype none
module cursor_line_edit_buffer #(
   parameter int CAPACITY = cleb_pkg::CAPACITY_DEF
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_ready,
   input  wire [cleb_pkg::MODE_W-1:0]     req_mode,
   input  wire [cleb_pkg::CHAR_W-1:0]     req_char_in,
   input  wire [cleb_pkg::POS_W-1:0]      req_read_pos,
   output logic                           rsp_valid,
   input  wire                            rsp_ready,
   output logic [cleb_pkg::CHAR_W-1:0]    rsp_char_out,
   output logic [cleb_pkg::STATUS_W-1:0]  rsp_status,
   output logic [cleb_pkg::LEN_W-1:0]     rsp_text_length,
   output logic [cleb_pkg::LEN_W-1:0]     rsp_cursor_pos
);

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int INFO_W = $bits(cleb_pkg::cmd_info_type);
   localparam int ENTRY_W = INFO_W + 2 * ADDR_W;

   logic                   queue_full, q_empty, push, pop;
   cleb_pkg::cmd_info_type push_info, head_info;
   logic [ADDR_W-1:0]      push_rd_addr, push_wr_addr, head_rd_addr, head_wr_addr;
   logic [ENTRY_W-1:0]     push_data, head_data;

   cleb_front #(
      .CAPACITY(CAPACITY),
      .ADDR_W(ADDR_W)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode(req_mode),
      .req_char_in(req_char_in),
      .req_read_pos(req_read_pos),
      .queue_full(queue_full),
      .push_valid(push),
      .push_info(push_info),
      .push_rd_addr(push_rd_addr),
      .push_wr_addr(push_wr_addr)
   );

   assign push_data = {push_info, push_rd_addr, push_wr_addr};

   cleb_queue #(
      .WIDTH(ENTRY_W),
      .DEPTH(cleb_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_data(push_data),
      .full(queue_full),
      .pop(pop),
      .head_data(head_data),
      .empty(q_empty)
   );

   assign head_info = cleb_pkg::cmd_info_type'(head_data[ENTRY_W-1 -: INFO_W]);
   assign head_rd_addr = head_data[2*ADDR_W-1 -: ADDR_W];
   assign head_wr_addr = head_data[ADDR_W-1:0];

   cleb_back #(
      .CAPACITY(CAPACITY),
      .ADDR_W(ADDR_W)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .q_empty(q_empty),
      .head_info(head_info),
      .head_rd_addr(head_rd_addr),
      .head_wr_addr(head_wr_addr),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_char_out(rsp_char_out),
      .rsp_status(rsp_status),
      .rsp_text_length(rsp_text_length),
      .rsp_cursor_pos(rsp_cursor_pos)
   );

endmodule
`default_nettype wire

[rtl/core/cleb_front.sv]
// Front end: accepts transactions, checks bounds, keeps the cursor counters.
`default_nettype none
module cleb_front #(
   parameter int CAPACITY = cleb_pkg::CAPACITY_DEF,
   parameter int ADDR_W = $clog2(CAPACITY)
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire [cleb_pkg::MODE_W-1:0]   req_mode,
   input  wire [cleb_pkg::CHAR_W-1:0]   req_char_in,
   input  wire [cleb_pkg::POS_W-1:0]    req_read_pos,
   input  wire                          queue_full,
   output logic                         push_valid,
   output cleb_pkg::cmd_info_type       push_info,
   output logic [ADDR_W-1:0]            push_rd_addr,
   output logic [ADDR_W-1:0]            push_wr_addr
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int WW = ((CNT_W > cleb_pkg::POS_W) ? CNT_W : cleb_pkg::POS_W) + 1;
   localparam logic [WW-1:0] CAP_W = WW'(CAPACITY);

   logic [CNT_W-1:0] left_ff, left_in;
   logic [CNT_W-1:0] right_ff, right_in;

   logic [WW-1:0] left_x, right_x, pos_x, len_x;
   logic [WW-1:0] rd_x, wr_x;
   logic          accept;

   assign req_ready = !queue_full;
   assign accept = req_valid && req_ready;
   assign left_x = WW'(left_ff);
   assign right_x = WW'(right_ff);
   assign pos_x = WW'(req_read_pos);
   assign len_x = left_x + right_x;

   always_comb begin
      left_in = left_ff;
      right_in = right_ff;
      rd_x = '0;
      wr_x = '0;
      push_info.op = cleb_pkg::OP_NONE;
      push_info.wdata = req_char_in;
      push_info.status = cleb_pkg::ST_DONE;
      case (req_mode)
         cleb_pkg::MODE_INSERT: begin
            if (len_x >= CAP_W) begin
               push_info.status = cleb_pkg::ST_FULL;
            end else begin
               push_info.op = cleb_pkg::OP_WRITE;
               wr_x = left_x;
               left_in = left_ff + CNT_W'(1);
            end
         end
         cleb_pkg::MODE_LEFT: begin
            if (left_ff == '0) begin
               push_info.status = cleb_pkg::ST_BOUNDARY;
            end else begin
               push_info.op = cleb_pkg::OP_COPY;
               rd_x = left_x - WW'(1);
               wr_x = CAP_W - right_x - WW'(1);
               left_in = left_ff - CNT_W'(1);
               right_in = right_ff + CNT_W'(1);
            end
         end
         cleb_pkg::MODE_RIGHT: begin
            if (right_ff == '0) begin
               push_info.status = cleb_pkg::ST_BOUNDARY;
            end else begin
               push_info.op = cleb_pkg::OP_COPY;
               rd_x = CAP_W - right_x;
               wr_x = left_x;
               left_in = left_ff + CNT_W'(1);
               right_in = right_ff - CNT_W'(1);
            end
         end
         cleb_pkg::MODE_BACK: begin
            if (left_ff == '0) begin
               push_info.status = cleb_pkg::ST_BOUNDARY;
            end else begin
               left_in = left_ff - CNT_W'(1);
            end
         end
         cleb_pkg::MODE_READ: begin
            if (pos_x >= len_x) begin
               push_info.status = cleb_pkg::ST_RANGE;
            end else begin
               push_info.op = cleb_pkg::OP_READ;
               if (pos_x < left_x) begin
                  rd_x = pos_x;
               end else begin
                  rd_x = CAP_W - right_x + pos_x - left_x;
               end
            end
         end
         default: begin
            push_info.status = cleb_pkg::ST_BOUNDARY;
         end
      endcase
      push_info.text_length = cleb_pkg::LEN_W'(WW'(left_in) + WW'(right_in));
      push_info.cursor_pos = cleb_pkg::LEN_W'(WW'(left_in));
   end

   assign push_valid = accept;
   assign push_rd_addr = ADDR_W'(rd_x);
   assign push_wr_addr = ADDR_W'(wr_x);

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         right_ff <= '0;
      end else if (accept) begin
         left_ff <= left_in;
         right_ff <= right_in;
      end
   end

endmodule
`default_nettype wire

[rtl/core/cleb_queue.sv]
// Command queue between the front end and the back end.
`default_nettype none
module cleb_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = cleb_pkg::QUEUE_DEPTH
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              push,
   input  wire [WIDTH-1:0]  push_data,
   output logic             full,
   input  wire              pop,
   output logic [WIDTH-1:0] head_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

[rtl/core/cleb_back.sv]
// Back end: text memory, copy/read sequencing and the response register.
`default_nettype none
module cleb_back #(
   parameter int CAPACITY = cleb_pkg::CAPACITY_DEF,
   parameter int ADDR_W = $clog2(CAPACITY)
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            q_empty,
   input  cleb_pkg::cmd_info_type         head_info,
   input  wire [ADDR_W-1:0]               head_rd_addr,
   input  wire [ADDR_W-1:0]               head_wr_addr,
   output logic                           pop,
   output logic                           rsp_valid,
   input  wire                            rsp_ready,
   output logic [cleb_pkg::CHAR_W-1:0]    rsp_char_out,
   output logic [cleb_pkg::STATUS_W-1:0]  rsp_status,
   output logic [cleb_pkg::LEN_W-1:0]     rsp_text_length,
   output logic [cleb_pkg::LEN_W-1:0]     rsp_cursor_pos
);

   logic [cleb_pkg::CHAR_W-1:0] mem_ff [CAPACITY];
   logic [cleb_pkg::CHAR_W-1:0] rdata_ff;

   cleb_pkg::back_state_type state_ff, state_in;
   cleb_pkg::cmd_info_type   cur_info_ff;
   logic [ADDR_W-1:0]        cur_wr_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [cleb_pkg::CHAR_W-1:0]  char_ff, char_in;
   logic [cleb_pkg::STATUS_W-1:0] status_ff;
   logic [cleb_pkg::LEN_W-1:0]   len_ff, cur_ff;

   logic                        slot_free;
   logic                        mem_re, mem_we, latch, load;
   logic [ADDR_W-1:0]           mem_waddr;
   logic [cleb_pkg::CHAR_W-1:0] mem_wdata;
   cleb_pkg::cmd_info_type      load_info;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      pop = 1'b0;
      mem_re = 1'b0;
      mem_we = 1'b0;
      latch = 1'b0;
      load = 1'b0;
      mem_waddr = head_wr_addr;
      mem_wdata = head_info.wdata;
      load_info = head_info;
      char_in = '0;
      case (state_ff)
         cleb_pkg::BK_IDLE: begin
            if (!q_empty) begin
               if (head_info.op inside {cleb_pkg::OP_READ, cleb_pkg::OP_COPY}) begin
                  pop = 1'b1;
                  mem_re = 1'b1;
                  latch = 1'b1;
                  state_in = cleb_pkg::BK_FINISH;
               end else if (slot_free) begin
                  pop = 1'b1;
                  load = 1'b1;
                  mem_we = (head_info.op == cleb_pkg::OP_WRITE);
               end
            end
         end
         cleb_pkg::BK_FINISH: begin
            if (slot_free) begin
               load = 1'b1;
               load_info = cur_info_ff;
               state_in = cleb_pkg::BK_IDLE;
               if (cur_info_ff.op == cleb_pkg::OP_COPY) begin
                  mem_we = 1'b1;
                  mem_waddr = cur_wr_ff;
                  mem_wdata = rdata_ff;
               end else begin
                  char_in = rdata_ff;
               end
            end
         end
         default: begin
            state_in = cleb_pkg::BK_IDLE;
         end
      endcase
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cleb_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (latch) begin
         cur_info_ff <= head_info;
         cur_wr_ff <= head_wr_addr;
      end
      if (load) begin
         char_ff <= char_in;
         status_ff <= load_info.status;
         len_ff <= load_info.text_length;
         cur_ff <= load_info.cursor_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem_ff[head_rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_char_out = char_ff;
   assign rsp_status = status_ff;
   assign rsp_text_length = len_ff;
   assign rsp_cursor_pos = cur_ff;

endmodule
`default_nettype wire
